// File: hw/rtl/second_order_lowpass_biquad_assert.svh
// Assertion macros shared by the biquad RTL.
// Needs nothing else; the including module supplies clock and reset names.
`ifndef SECOND_ORDER_LOWPASS_BIQUAD_ASSERT_SVH
`define SECOND_ORDER_LOWPASS_BIQUAD_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOLB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SOLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/solb_pkg.sv
// Package for the second order low-pass biquad: defaults, codes and the microprogram.
// Used by second_order_lowpass_biquad.sv; depends on nothing.
`default_nettype none

package solb_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int DELAY_WIDTH_DEF    = 24;
    localparam int CFG_INDEX_W        = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FEED0 = 3'd0,
        REG_FEED1 = 3'd1,
        REG_FEED2 = 3'd2,
        REG_BACK1 = 3'd3,
        REG_BACK2 = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_WAIT     = 4'd0,
        S_PRE_SUM  = 4'd1,
        S_DIV_INIT = 4'd2,
        S_DIV_LOOP = 4'd3,
        S_PRE_WR   = 4'd4,
        S_F_MUL1   = 4'd5,
        S_F_MUL2   = 4'd6,
        S_F_SUB2   = 4'd7,
        S_F_W      = 4'd8,
        S_F_MUL3   = 4'd9,
        S_F_MUL4   = 4'd10,
        S_F_MUL5   = 4'd11,
        S_F_ADD3   = 4'd12,
        S_F_OUT    = 4'd13
    } t_step;

    typedef enum logic [1:0] {A_D1, A_D2, A_W} t_asel;

    typedef enum logic [2:0] {B_FEED0, B_FEED1, B_FEED2, B_BACK1, B_BACK2} t_bsel;

    typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD_X, ACC_LOAD_P, ACC_ADD, ACC_SUB} t_accop;

    // J_ACCEPT waits for an item, J_LOOP runs the divider count down,
    // J_OUT waits for the output register to be free.
    typedef enum logic [1:0] {J_NEXT, J_ACCEPT, J_LOOP, J_OUT} t_jump;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        t_accop acc_op;
        logic   sum_en;
        logic   div_init;
        logic   div_step;
        logic   pre_wr;
        logic   take_w;
        logic   emit;
        t_jump  jump;
        t_step  target;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl cw;
        cw = '0;
        unique case (step)
            S_WAIT: begin
                cw.jump   = J_ACCEPT;
                cw.target = S_F_MUL1;
            end
            S_PRE_SUM:  cw.sum_en = 1'b1;
            S_DIV_INIT: cw.div_init = 1'b1;
            S_DIV_LOOP: begin
                cw.div_step = 1'b1;
                cw.jump     = J_LOOP;
            end
            S_PRE_WR:   cw.pre_wr = 1'b1;
            S_F_MUL1: begin
                cw.acc_op = ACC_LOAD_X;
                cw.a_sel  = A_D1;
                cw.b_sel  = B_BACK1;
            end
            S_F_MUL2: begin
                cw.acc_op = ACC_SUB;
                cw.a_sel  = A_D2;
                cw.b_sel  = B_BACK2;
            end
            S_F_SUB2:   cw.acc_op = ACC_SUB;
            S_F_W:      cw.take_w = 1'b1;
            S_F_MUL3: begin
                cw.a_sel = A_W;
                cw.b_sel = B_FEED0;
            end
            S_F_MUL4: begin
                cw.acc_op = ACC_LOAD_P;
                cw.a_sel  = A_D1;
                cw.b_sel  = B_FEED1;
            end
            S_F_MUL5: begin
                cw.acc_op = ACC_ADD;
                cw.a_sel  = A_D2;
                cw.b_sel  = B_FEED2;
            end
            S_F_ADD3:   cw.acc_op = ACC_ADD;
            S_F_OUT: begin
                cw.emit   = 1'b1;
                cw.jump   = J_OUT;
                cw.target = S_WAIT;
            end
            default: begin
                // Unused step codes fall back to the wait step.
                cw.jump   = J_OUT;
                cw.target = S_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/second_order_lowpass_biquad.sv
// Direct form II biquad run by a microprogram over one shared multiplier; uses solb_pkg.
// A filter item runs the nine-step multiply-accumulate program on the single multiplier and
// leaves its result in the output step; a new item is taken only after that step has emitted.
// A preload item first runs the pre-sum, divider setup, divider loop and preload write steps
// for the one-bit-per-cycle restoring divider. Synchronous reset restores pass-through coefficients,
// clears both delay words and empties the output register.
`default_nettype none
`include "second_order_lowpass_biquad_assert.svh"

module second_order_lowpass_biquad #(
    parameter int SAMPLE_WIDTH   = solb_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = solb_pkg::COEF_FRAC_BITS_DEF,
    parameter int DELAY_WIDTH    = solb_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [solb_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [COEF_FRAC_BITS+1:0]           i_cfg_data,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: sample [SAMPLE_WIDTH-1:0], zero padded to whole bytes
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    // tuser: op (0 filter, 1 preload then filter)
    input  wire logic                                i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: filtered [SAMPLE_WIDTH-1:0], zero padded to whole bytes
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        o_m_axis_tdata
);

    import solb_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int F    = COEF_FRAC_BITS;
    localparam int DW   = DELAY_WIDTH;
    localparam int CW   = F + 2;
    localparam int SUMW = CW + 2;
    localparam int NUMW = SW + F + 1;
    localparam int CNTW = $clog2(NUMW + 1);
    localparam int PW   = DW + CW;
    localparam int XW   = (SW > DW) ? SW : DW;
    localparam int AW   = ((PW > SW + CW) ? PW : SW + CW) + 2;
    localparam int RW   = AW - F;
    localparam int QW   = ((NUMW > DW) ? NUMW : DW) + 1;
    localparam int TDW  = ((SW + 7) / 8) * 8;

    localparam logic signed [DW-1:0] D_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN   = ~D_MAX;
    localparam logic signed [SW-1:0] S_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN   = ~S_MAX;
    localparam logic signed [AW-1:0] HALF    = AW'(1) << (F - 1);
    localparam logic [QW-1:0]        Q_LIMIT = QW'(1) << (DW - 1);
    localparam logic [CNTW-1:0]      CNT_ONE = CNTW'(1);

    // Sequencer
    t_step r_step, n_step;
    t_ctrl cw;
    logic  accept;
    logic  out_free;
    logic  emit_fire;
    logic  cfg_hit;

    // Coefficients and state
    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [DW-1:0] r_d1, r_d2, r_w;

    // Datapath
    logic signed [SW-1:0]   r_x;
    logic signed [DW-1:0]   mul_a;
    logic signed [CW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_p, r_prod;
    logic signed [AW-1:0]   r_acc, rnd;
    logic signed [RW-1:0]   rq;
    logic                   w_fits, y_fits;
    logic signed [SW-1:0]   y_sat;
    logic signed [XW-1:0]   x_ext;
    logic                   x_fits;
    logic signed [DW-1:0]   xd;

    // Preload divider
    logic signed [SUMW-1:0] r_sum;
    logic [SUMW-1:0]        den_now, r_den;
    logic [SW-1:0]          mag_x;
    logic [NUMW-1:0]        r_num;
    logic [SUMW-1:0]        r_rem;
    logic [CNTW-1:0]        r_cnt;
    logic [SUMW:0]          trial, diff;
    logic                   ge;
    logic [QW-1:0]          q_ext;
    logic                   q_neg, q_ok;
    logic signed [DW-1:0]   q_val, pre;

    logic                   r_out_valid;
    logic [SW-1:0]          r_out_data;

    assign cw        = ucode(r_step);
    assign o_s_axis_tready = (cw.jump == J_ACCEPT);
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign emit_fire = cw.emit && out_free;
    assign cfg_hit   = i_cfg_we && (i_cfg_index <= REG_BACK2);

    always_comb begin
        n_step = r_step;
        unique case (cw.jump)
            J_NEXT:   n_step = t_step'(r_step + 4'd1);
            J_ACCEPT: begin
                if (accept) begin
                    n_step = i_s_axis_tuser ? t_step'(r_step + 4'd1) : cw.target;
                end
            end
            J_LOOP:   begin
                if (r_cnt == CNT_ONE) begin
                    n_step = t_step'(r_step + 4'd1);
                end
            end
            J_OUT:    begin
                if (out_free) begin
                    n_step = cw.target;
                end
            end
            default:  n_step = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= CW'(1) << F;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FEED0: r_b0 <= i_cfg_data;
                REG_FEED1: r_b1 <= i_cfg_data;
                REG_FEED2: r_b2 <= i_cfg_data;
                REG_BACK1: r_a1 <= i_cfg_data;
                REG_BACK2: r_a2 <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Sample saturated to the delay range, the fallback value for w and the preload.
    assign x_ext  = XW'(r_x);
    assign x_fits = (XW'($signed(x_ext[DW-1:0])) == x_ext);
    assign xd     = x_fits ? x_ext[DW-1:0] : (r_x[SW-1] ? D_MIN : D_MAX);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= $signed(i_s_axis_tdata[SW-1:0]);
        end
    end

    // Shared multiplier with a registered product.
    always_comb begin
        unique case (cw.a_sel)
            A_D1:    mul_a = r_d1;
            A_D2:    mul_a = r_d2;
            A_W:     mul_a = r_w;
            default: mul_a = r_d1;
        endcase
        unique case (cw.b_sel)
            B_FEED0: mul_b = r_b0;
            B_FEED1: mul_b = r_b1;
            B_FEED2: mul_b = r_b2;
            B_BACK1: mul_b = r_a1;
            B_BACK2: mul_b = r_a2;
            default: mul_b = r_b0;
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    always_ff @(posedge i_clk) begin
        unique case (cw.acc_op)
            ACC_HOLD:   r_acc <= r_acc;
            ACC_LOAD_X: r_acc <= AW'(r_x) <<< F;
            ACC_LOAD_P: r_acc <= AW'(r_prod);
            ACC_ADD:    r_acc <= r_acc + AW'(r_prod);
            ACC_SUB:    r_acc <= r_acc - AW'(r_prod);
            default:    r_acc <= r_acc;
        endcase
    end

    // Round half up, then check the range of the delay word and of the output.
    assign rnd    = r_acc + HALF;
    assign rq     = rnd[AW-1:F];
    assign w_fits = (RW'($signed(rq[DW-1:0])) == rq);
    assign y_fits = (RW'($signed(rq[SW-1:0])) == rq);
    assign y_sat  = y_fits ? rq[SW-1:0] : (rq[RW-1] ? S_MIN : S_MAX);

    always_ff @(posedge i_clk) begin
        if (cw.take_w) begin
            r_w <= w_fits ? rq[DW-1:0] : xd;
        end
    end

    // Preload: round(|x| * 2^F / |b0+b1+b2|) by restoring division, one bit per cycle.
    assign den_now = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign mag_x   = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);
    assign trial   = {r_rem, r_num[NUMW-1]};
    assign diff    = trial - {1'b0, r_den};
    assign ge      = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (cw.sum_en) begin
            r_sum <= SUMW'(r_b0) + SUMW'(r_b1) + SUMW'(r_b2);
        end
        if (cw.div_init) begin
            r_den <= den_now;
            r_num <= (NUMW'(mag_x) << F) + NUMW'(den_now >> 1);
            r_rem <= '0;
        end else if (cw.div_step) begin
            r_rem <= ge ? diff[SUMW-1:0] : trial[SUMW-1:0];
            r_num <= {r_num[NUMW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (cw.div_init) begin
            r_cnt <= CNTW'(NUMW);
        end else if (cw.div_step) begin
            r_cnt <= r_cnt - CNT_ONE;
        end
    end

    // The quotient r_num becomes the preload when b0+b1+b2 is nonzero and it lands in the delay range.
    assign q_ext = QW'(r_num);
    assign q_neg = r_x[SW-1] ^ r_sum[SUMW-1];
    assign q_ok  = (r_sum != '0) && ((q_ext < Q_LIMIT) || (q_neg && (q_ext == Q_LIMIT)));
    assign q_val = q_neg ? -DW'(r_num) : DW'(r_num);
    assign pre   = q_ok ? q_val : xd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (cfg_hit) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (cw.pre_wr) begin
            r_d1 <= pre;
            r_d2 <= pre;
        end else if (emit_fire) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_data <= y_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDW'(r_out_data);

    `SOLB_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, accept, r_step == S_PRE_SUM || r_step == S_F_MUL1, "accepted item did not start the preload or the filter program")
    `SOLB_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_step == S_F_OUT && r_out_valid && !i_m_axis_tready, r_step == S_F_OUT && $stable(r_d1), "delay line moved while the result was stalled")
    `SOLB_ASSERT_SAME(a_result_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_step) == S_F_OUT, "result appeared outside the output step")
    `SOLB_ASSERT_SAME(a_div_count, i_clk, i_rst_n, r_step == S_DIV_LOOP, r_cnt != '0, "divider loop running with an exhausted count")
    `SOLB_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, cfg_hit, r_d1 == '0 && r_d2 == '0, "coefficient write did not clear the delay words")

endmodule

`default_nettype wire
